FILE: rtl/tlsp_pkg.sv
// Package for the typed list stream parser.
// Holds payload and queue types, magic constants, event and error codes.
// No dependencies.
`default_nettype none

package tlsp_pkg;

    localparam logic [63:0] BEGIN_MAGIC = 64'hFF18_D1C0_B1A3_26FF;
    localparam logic [63:0] END_MAGIC   = 64'hFF26_A3B1_C0D1_18FF;

    localparam logic [3:0] HDR_LEN   = 4'd8;
    localparam logic [3:0] HOLD_LEN  = 4'd8;
    localparam logic [3:0] WIDE_LEN  = 4'd8;
    localparam logic [3:0] BOOL_LEN  = 4'd1;
    localparam logic [3:0] SLEN_LEN  = 4'd4;

    localparam logic [2:0] EV_INT       = 3'd0;
    localparam logic [2:0] EV_DBL       = 3'd1;
    localparam logic [2:0] EV_BOOL      = 3'd2;
    localparam logic [2:0] EV_STR_START = 3'd3;
    localparam logic [2:0] EV_STR_BYTE  = 3'd4;
    localparam logic [2:0] EV_OK        = 3'd5;
    localparam logic [2:0] EV_ERR       = 3'd6;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NOT_LIST = 2'd1;
    localparam logic [1:0] ERR_CORRUPT  = 2'd2;

    localparam logic [1:0] CFG_CODE_INT64  = 2'd0;
    localparam logic [1:0] CFG_CODE_DOUBLE = 2'd1;
    localparam logic [1:0] CFG_CODE_BOOL   = 2'd2;
    localparam logic [1:0] CFG_CODE_STRING = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_FIXED = 2'd1,
        PH_LEN   = 2'd2,
        PH_STR   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [63:0] value;
        logic [1:0]  error_code;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic      two;
        t_out_item r0;
        t_out_item r1;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

FILE: rtl/typed_list_stream_parser_top.sv
// Channel   Direction  Handshake            Payload
// in        sink       i_in_valid/o_in_stall   i_in_item (t_in_item)
// out       source     o_out_valid/i_out_stall o_out_item (t_out_item)
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte per cycle in unless stalled; the front end updates all parse state.
// A byte with two results is sent as two items by the registered output stage.
// The queue (QUEUE_DEPTH entries) absorbs output stalls; input stalls when full.
// Synchronous active-low reset restores type codes and clears all parse state.
// Top level of the typed list stream parser; uses tlsp_pkg, tlsp_front,
// tlsp_queue and tlsp_back.
`default_nettype none

module typed_list_stream_parser_top #(
    parameter int QUEUE_DEPTH = tlsp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire tlsp_pkg::t_in_item               i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output tlsp_pkg::t_out_item                   o_out_item,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [tlsp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tlsp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tlsp_pkg::*;

    logic      accept;
    logic      push;
    logic      pop;
    t_q_entry  entry;
    t_q_entry  head;
    t_q_status status;

    assign o_in_stall  = status.full;
    assign accept      = i_in_valid && !status.full;
    assign o_cfg_ready = 1'b1;

    tlsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_entry     (entry)
    );

    tlsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    tlsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

FILE: rtl/tlsp_front.sv
// Front end: accepts bytes, checks the magics, parses records.
// Packs the one or two results of each byte into a queue entry. Uses tlsp_pkg.
`default_nettype none

module tlsp_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire tlsp_pkg::t_in_item               i_in_item,
    input  wire logic                             i_cfg_we,
    input  wire logic [tlsp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [tlsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                  o_push,
    output tlsp_pkg::t_q_entry                    o_entry
);
    import tlsp_pkg::*;

    logic [7:0]  r_code_int, r_code_dbl, r_code_bool, r_code_str;
    logic [63:0] r_hold, n_hold;
    logic [3:0]  r_hold_cnt, n_hold_cnt;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_rtype, n_rtype;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_fcnt, n_fcnt;
    logic [31:0] r_str_rem, n_str_rem;
    logic        r_err, n_err;

    t_out_item   res_a, res_b;
    logic        has_a, has_b;
    logic [7:0]  pb;
    logic [3:0]  fcnt_inc;
    logic [3:0]  need;
    logic        fin;

    assign pb       = r_hold[7:0];
    assign fcnt_inc = r_fcnt + 4'd1;
    assign need     = (r_rtype == EV_BOOL[1:0]) ? BOOL_LEN : WIDE_LEN;
    assign fin      = i_in_item.final_byte;

    always_comb begin
        n_hold     = r_hold;
        n_hold_cnt = r_hold_cnt;
        n_hdr_cnt  = r_hdr_cnt;
        n_phase    = r_phase;
        n_rtype    = r_rtype;
        n_acc      = r_acc;
        n_fcnt     = r_fcnt;
        n_str_rem  = r_str_rem;
        n_err      = r_err;
        res_a      = '0;
        res_b      = '0;
        has_a      = 1'b0;
        has_b      = 1'b0;

        if (!r_err) begin
            if (r_hdr_cnt < HDR_LEN) begin
                if (i_in_item.data_byte != BEGIN_MAGIC[{r_hdr_cnt[2:0], 3'b000} +: 8]) begin
                    has_a            = 1'b1;
                    res_a.event_res  = EV_ERR;
                    res_a.error_code = ERR_NOT_LIST;
                    n_err            = 1'b1;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                end
            end else begin
                if (r_hold_cnt >= HOLD_LEN) begin
                    case (r_phase)
                        PH_FIXED: begin
                            n_acc[{r_fcnt[2:0], 3'b000} +: 8] = pb;
                            n_fcnt = fcnt_inc;
                            if (fcnt_inc >= need) begin
                                n_phase         = PH_TYPE;
                                has_a           = 1'b1;
                                res_a.event_res = {1'b0, r_rtype};
                                res_a.value     = n_acc;
                            end
                        end
                        PH_LEN: begin
                            n_acc[{r_fcnt[1:0], 3'b000} +: 8] = pb;
                            n_fcnt = fcnt_inc;
                            if (fcnt_inc >= SLEN_LEN) begin
                                n_str_rem       = n_acc[31:0];
                                n_phase         = (n_acc[31:0] != 32'd0) ? PH_STR : PH_TYPE;
                                has_a           = 1'b1;
                                res_a.event_res = EV_STR_START;
                                res_a.value     = {32'd0, n_acc[31:0]};
                            end
                        end
                        PH_STR: begin
                            n_str_rem = r_str_rem - 32'd1;
                            if (n_str_rem == 32'd0) begin
                                n_phase = PH_TYPE;
                            end
                            has_a           = 1'b1;
                            res_a.event_res = EV_STR_BYTE;
                            res_a.value     = {56'd0, pb};
                        end
                        PH_TYPE: begin
                            n_acc  = '0;
                            n_fcnt = '0;
                            if (pb == r_code_int) begin
                                n_rtype = EV_INT[1:0];
                                n_phase = PH_FIXED;
                            end else if (pb == r_code_dbl) begin
                                n_rtype = EV_DBL[1:0];
                                n_phase = PH_FIXED;
                            end else if (pb == r_code_bool) begin
                                n_rtype = EV_BOOL[1:0];
                                n_phase = PH_FIXED;
                            end else if (pb == r_code_str) begin
                                n_rtype = EV_STR_START[1:0];
                                n_phase = PH_LEN;
                            end else begin
                                has_a            = 1'b1;
                                res_a.event_res  = EV_ERR;
                                res_a.error_code = ERR_CORRUPT;
                                n_err            = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_TYPE;
                        end
                    endcase
                end else begin
                    n_hold_cnt = r_hold_cnt + 4'd1;
                end
                n_hold = {i_in_item.data_byte, r_hold[63:8]};
            end

            if (fin && !n_err) begin
                has_b = 1'b1;
                if (n_hdr_cnt < HDR_LEN || n_hold_cnt < HOLD_LEN) begin
                    res_b.event_res  = EV_ERR;
                    res_b.error_code = ERR_NOT_LIST;
                end else if (n_hold != END_MAGIC) begin
                    res_b.event_res  = EV_ERR;
                    res_b.error_code = ERR_NOT_LIST;
                end else if (n_phase != PH_TYPE) begin
                    res_b.event_res  = EV_ERR;
                    res_b.error_code = ERR_CORRUPT;
                end else begin
                    res_b.event_res  = EV_OK;
                end
            end
        end

        // Clear all parse state after the final byte
        if (fin) begin
            n_hold     = '0;
            n_hold_cnt = '0;
            n_hdr_cnt  = '0;
            n_phase    = PH_TYPE;
            n_rtype    = '0;
            n_acc      = '0;
            n_fcnt     = '0;
            n_str_rem  = '0;
            n_err      = 1'b0;
        end
    end

    always_comb begin
        o_push        = i_accept && (has_a || has_b);
        o_entry.two   = has_a && has_b;
        o_entry.r0    = has_a ? res_a : res_b;
        o_entry.r0.last = !(has_a && has_b);
        o_entry.r1      = res_b;
        o_entry.r1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_int  <= 8'd0;
            r_code_dbl  <= 8'd1;
            r_code_bool <= 8'd2;
            r_code_str  <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CODE_INT64:  r_code_int  <= i_cfg_data;
                CFG_CODE_DOUBLE: r_code_dbl  <= i_cfg_data;
                CFG_CODE_BOOL:   r_code_bool <= i_cfg_data;
                CFG_CODE_STRING: r_code_str  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold     <= '0;
            r_hold_cnt <= '0;
            r_hdr_cnt  <= '0;
            r_phase    <= PH_TYPE;
            r_rtype    <= '0;
            r_acc      <= '0;
            r_fcnt     <= '0;
            r_str_rem  <= '0;
            r_err      <= 1'b0;
        end else if (i_accept) begin
            r_hold     <= n_hold;
            r_hold_cnt <= n_hold_cnt;
            r_hdr_cnt  <= n_hdr_cnt;
            r_phase    <= n_phase;
            r_rtype    <= n_rtype;
            r_acc      <= n_acc;
            r_fcnt     <= n_fcnt;
            r_str_rem  <= n_str_rem;
            r_err      <= n_err;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tlsp_queue.sv
// Short queue of result entries between front and back end.
// Register storage, one read port at the head. Uses tlsp_pkg.
`default_nettype none

module tlsp_queue #(
    parameter int DEPTH = tlsp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire tlsp_pkg::t_q_entry i_entry,
    input  wire logic               i_pop,
    output tlsp_pkg::t_q_entry      o_head,
    output tlsp_pkg::t_q_status     o_status
);
    import tlsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_FULL);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count out of range");

    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

FILE: rtl/tlsp_back.sv
// Back end: splits queue entries into single results on a registered output.
// Uses tlsp_pkg.
`default_nettype none

module tlsp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tlsp_pkg::t_q_entry  i_head,
    input  wire tlsp_pkg::t_q_status i_status,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output tlsp_pkg::t_out_item      o_out_item
);
    import tlsp_pkg::*;

    logic      r_valid, n_valid;
    logic      r_sel, n_sel;
    t_out_item r_item, n_item;
    logic      load;

    assign load        = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        n_item  = r_item;
        o_pop   = 1'b0;
        if (load) begin
            if (!i_status.empty) begin
                n_valid = 1'b1;
                n_item  = r_sel ? i_head.r1 : i_head.r0;
                if (r_sel || !i_head.two) begin
                    o_pop = 1'b1;
                    n_sel = 1'b0;
                end else begin
                    n_sel = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

`default_nettype wire
